/* hw/rtl/tspg_pkg.sv */
// Shared types and constants for the two-axis step pulse generator.
`timescale 1ns / 1ps
`default_nettype none
package tspg_pkg;

	// position register width; the ports stay 16 bits
	localparam int unsigned POS_BITS    = 16;
	localparam int unsigned FIELD_BITS  = 16;
	localparam int unsigned RELOAD_BITS = 16;
	localparam int unsigned VEL_BITS    = 7;
	localparam int unsigned CFG_IDX_BITS = 8;

	localparam logic [VEL_BITS-1:0] FULL_SPEED = VEL_BITS'(100);

	// register indexes of the configuration port
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_RELOAD = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_RELOAD = CFG_IDX_BITS'(1);

	localparam logic [RELOAD_BITS-1:0] MIN_RELOAD_RST = RELOAD_BITS'(1);
	localparam logic [RELOAD_BITS-1:0] MAX_RELOAD_RST = RELOAD_BITS'(100);

	// speed split: q^2 * (dx^2 + dy^2) <= v^2 * d^2
	localparam int unsigned SQ_BITS   = 2 * POS_BITS;
	localparam int unsigned SUM_BITS  = SQ_BITS + 1;
	localparam int unsigned VSQ_BITS  = 2 * VEL_BITS;
	localparam int unsigned TGT_BITS  = VSQ_BITS + SQ_BITS;
	localparam int unsigned ACC_BITS  = SUM_BITS + VSQ_BITS + 1;

	// reload: |speed * (min - max)| / 100 by reciprocal multiply
	localparam int unsigned PROD_BITS   = VEL_BITS + RELOAD_BITS;
	localparam int unsigned RECIP_SHIFT = PROD_BITS + VEL_BITS;
	localparam int unsigned RECIP_BITS  = RECIP_SHIFT - VEL_BITS + 1;
	localparam logic [RECIP_BITS-1:0] RECIP_MUL =
		RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100);
	localparam int unsigned DIVP_BITS = PROD_BITS + RECIP_BITS;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_MV_DIST,
		ST_MV_SQ,
		ST_MV_SUM,
		ST_MV_INIT,
		ST_MV_ITER,
		ST_MV_COMMIT,
		ST_TK_MUL,
		ST_TK_DIV,
		ST_TK_UPD,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic latch_in;
		logic calc_dist;
		logic calc_sq;
		logic calc_sum;
		logic init_axis;
		logic iter_step;
		logic axis;
		logic mv_commit;
		logic tk_mul;
		logic tk_div;
		logic tk_upd;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic is_move;
		logic iter_done;
	} dp_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/tspg_ctrl.sv */
// Controller state machine: sequences move and tick words through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module tspg_ctrl
	import tspg_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	output dp_cmd_t       cmd,
	input  wire dp_stat_t stat
);

	state_t state_q, state_d;
	logic   axis_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE)
				axis_q <= 1'b0;
			else if (state_q == ST_MV_ITER && stat.iter_done)
				axis_q <= 1'b1;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (in_valid) state_d = ST_DISPATCH;
			ST_DISPATCH:  state_d = stat.is_move ? ST_MV_DIST : ST_TK_MUL;
			ST_MV_DIST:   state_d = ST_MV_SQ;
			ST_MV_SQ:     state_d = ST_MV_SUM;
			ST_MV_SUM:    state_d = ST_MV_INIT;
			ST_MV_INIT:   state_d = ST_MV_ITER;
			ST_MV_ITER: begin
				if (stat.iter_done)
					state_d = axis_q ? ST_MV_COMMIT : ST_MV_INIT;
			end
			ST_MV_COMMIT: state_d = ST_FINISH;
			ST_TK_MUL:    state_d = ST_TK_DIV;
			ST_TK_DIV:    state_d = ST_TK_UPD;
			ST_TK_UPD:    state_d = ST_FINISH;
			ST_FINISH:    if (slot_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.axis = axis_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.latch_in = in_valid;
			end
			ST_DISPATCH:  ;
			ST_MV_DIST:   cmd.calc_dist = 1'b1;
			ST_MV_SQ:     cmd.calc_sq = 1'b1;
			ST_MV_SUM:    cmd.calc_sum = 1'b1;
			ST_MV_INIT:   cmd.init_axis = 1'b1;
			ST_MV_ITER:   cmd.iter_step = 1'b1;
			ST_MV_COMMIT: cmd.mv_commit = 1'b1;
			ST_TK_MUL:    cmd.tk_mul = 1'b1;
			ST_TK_DIV:    cmd.tk_div = 1'b1;
			ST_TK_UPD:    cmd.tk_upd = 1'b1;
			ST_FINISH:    cmd.load_out = slot_free;
			default:      ;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

/* hw/rtl/tspg_dp.sv */
// Datapath: axis state, speed split search, reload arithmetic and result register.
`timescale 1ns / 1ps
`default_nettype none
module tspg_dp
	import tspg_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire dp_cmd_t                 cmd,
	output dp_stat_t                     stat,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [FIELD_BITS-1:0]   cfg_data,
	input  wire logic                    action,
	input  wire logic [FIELD_BITS-1:0]   target_x,
	input  wire logic [FIELD_BITS-1:0]   target_y,
	input  wire logic [FIELD_BITS-1:0]   velocity,
	output logic                         step_x,
	output logic                         dir_x,
	output logic                         step_y,
	output logic                         dir_y,
	output logic [FIELD_BITS-1:0]        pos_x,
	output logic [FIELD_BITS-1:0]        pos_y,
	output logic                         done_x,
	output logic                         done_y
);

	// configuration
	logic [RELOAD_BITS-1:0] min_reload_q, max_reload_q;

	// latched input word
	logic                act_q;
	logic [POS_BITS-1:0] tgt_q [2];
	logic [VEL_BITS-1:0] vel_q;

	// axis state
	logic [POS_BITS-1:0]    now_q  [2];
	logic [POS_BITS-1:0]    goal_q [2];
	logic [RELOAD_BITS-1:0] cnt_q  [2];
	logic [VEL_BITS-1:0]    spd_q  [2];
	logic [1:0]             dir_q;
	logic [1:0]             done_q;
	logic [1:0]             step_q;

	// speed split working registers
	logic [POS_BITS-1:0] dist_q [2];
	logic [SQ_BITS-1:0]  sq_q   [2];
	logic [VSQ_BITS-1:0] vsq_q;
	logic [SUM_BITS-1:0] sum_q;
	logic [ACC_BITS-1:0] t_q, lacc_q, dacc_q;
	logic [VEL_BITS-1:0] qcnt_q;

	// reload working registers
	logic [PROD_BITS-1:0]   prod_q [2];
	logic                   neg_q;
	logic [RELOAD_BITS-1:0] quot_q [2];

	// output word
	logic [1:0]          ostep_q, odir_q, odone_q;
	logic [POS_BITS-1:0] opos_q [2];

	logic [ACC_BITS-1:0]    cand;
	logic [TGT_BITS-1:0]    tprod;
	logic                   iter_ok;
	logic [RELOAD_BITS:0]   rdiff;
	logic [RELOAD_BITS-1:0] rmag;
	logic [1:0]             busy, dir_new;
	logic [RELOAD_BITS-1:0] reload [2];
	logic [POS_BITS-1:0]    next_pos [2];
	logic [DIVP_BITS-1:0]   divp [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_reload_q <= MIN_RELOAD_RST;
			max_reload_q <= MAX_RELOAD_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_MIN_RELOAD)
				min_reload_q <= cfg_data;
			else if (cfg_index == REG_MAX_RELOAD)
				max_reload_q <= cfg_data;
		end
	end

	// search step: L(q+1) = L(q) + D(q), D(q+1) = D(q) + 2S
	assign cand    = lacc_q + dacc_q;
	assign iter_ok = (qcnt_q < vel_q) && (dist_q[cmd.axis] != '0) && (cand <= t_q);
	assign tprod   = TGT_BITS'(vsq_q) * TGT_BITS'(sq_q[cmd.axis]);

	assign stat.is_move   = act_q;
	assign stat.iter_done = !iter_ok;

	assign rdiff = {1'b0, min_reload_q} - {1'b0, max_reload_q};
	assign rmag  = rdiff[RELOAD_BITS] ? RELOAD_BITS'(-rdiff) : rdiff[RELOAD_BITS-1:0];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			busy[i]     = (goal_q[i] != now_q[i]) && !done_q[i];
			dir_new[i]  = goal_q[i] >= now_q[i];
			reload[i]   = neg_q ? max_reload_q - quot_q[i] : max_reload_q + quot_q[i];
			next_pos[i] = dir_new[i] ? now_q[i] + POS_BITS'(1) : now_q[i] - POS_BITS'(1);
			divp[i]     = DIVP_BITS'(prod_q[i]) * DIVP_BITS'(RECIP_MUL);
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			act_q  <= action;
			tgt_q[0] <= POS_BITS'(target_x);
			tgt_q[1] <= POS_BITS'(target_y);
			vel_q  <= (velocity > FIELD_BITS'(FULL_SPEED)) ? FULL_SPEED
				: velocity[VEL_BITS-1:0];
		end
		if (cmd.calc_dist) begin
			for (int i = 0; i < 2; i++)
				dist_q[i] <= (tgt_q[i] >= goal_q[i]) ? tgt_q[i] - goal_q[i]
					: goal_q[i] - tgt_q[i];
		end
		if (cmd.calc_sq) begin
			for (int i = 0; i < 2; i++)
				sq_q[i] <= SQ_BITS'(dist_q[i]) * SQ_BITS'(dist_q[i]);
			vsq_q <= VSQ_BITS'(vel_q) * VSQ_BITS'(vel_q);
		end
		if (cmd.calc_sum)
			sum_q <= SUM_BITS'(sq_q[0]) + SUM_BITS'(sq_q[1]);
		if (cmd.init_axis) begin
			t_q    <= ACC_BITS'(tprod);
			lacc_q <= '0;
			dacc_q <= ACC_BITS'(sum_q);
			qcnt_q <= '0;
		end else if (cmd.iter_step && iter_ok) begin
			lacc_q <= cand;
			dacc_q <= dacc_q + (ACC_BITS'(sum_q) << 1);
			qcnt_q <= qcnt_q + VEL_BITS'(1);
		end
		if (cmd.tk_mul) begin
			for (int i = 0; i < 2; i++)
				prod_q[i] <= PROD_BITS'(spd_q[i]) * PROD_BITS'(rmag);
			neg_q <= rdiff[RELOAD_BITS];
		end
		if (cmd.tk_div) begin
			for (int i = 0; i < 2; i++)
				quot_q[i] <= RELOAD_BITS'(divp[i] >> RECIP_SHIFT);
		end
		if (cmd.load_out) begin
			ostep_q <= step_q;
			odir_q  <= dir_q;
			odone_q <= done_q;
			opos_q  <= now_q;
		end
	end

	// axis state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				now_q[i]  <= '0;
				goal_q[i] <= '0;
				cnt_q[i]  <= '0;
				spd_q[i]  <= '0;
			end
			dir_q  <= '0;
			done_q <= '1;
			step_q <= '0;
		end else begin
			if (cmd.iter_step && !iter_ok)
				spd_q[cmd.axis] <= qcnt_q;
			if (cmd.mv_commit) begin
				for (int i = 0; i < 2; i++) begin
					goal_q[i] <= tgt_q[i];
					cnt_q[i]  <= '0;
				end
				done_q <= '0;
				step_q <= '0;
			end
			if (cmd.tk_upd) begin
				for (int i = 0; i < 2; i++) begin
					step_q[i] <= 1'b0;
					if (busy[i]) begin
						dir_q[i] <= dir_new[i];
						if (cnt_q[i] != '0) begin
							cnt_q[i] <= cnt_q[i] - RELOAD_BITS'(1);
						end else begin
							now_q[i]  <= next_pos[i];
							cnt_q[i]  <= reload[i];
							step_q[i] <= 1'b1;
						end
					end else begin
						done_q[i] <= 1'b1;
					end
				end
			end
		end
	end

	assign step_x = ostep_q[0];
	assign step_y = ostep_q[1];
	assign dir_x  = odir_q[0];
	assign dir_y  = odir_q[1];
	assign done_x = odone_q[0];
	assign done_y = odone_q[1];
	assign pos_x  = FIELD_BITS'(opos_q[0]);
	assign pos_y  = FIELD_BITS'(opos_q[1]);

endmodule
`default_nettype wire

/* hw/rtl/two_axis_step_pulse_generator_top.sv */
// Top level of the two-axis step/direction pulse generator.
//
//  channel | handshake             | word
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_ready   | action, target_x, target_y, velocity
//  out     | out_valid / out_ready | step_x/y, dir_x/y, pos_x/y, done_x/y
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (min/max reload)
//
// A tick word runs through the dispatch, multiply, divide, update and finish states.
// A move word runs through distance, square and sum, then an init and a search per
// axis, then commit: the split is a search of one candidate speed a cycle.
// One word is in work at a time; a finished word waits in the output register
// and only holds the controller once the next result is ready too.
// Reset restores the reload registers to 1 and 100 and all axes to done at 0.
`timescale 1ns / 1ps
`default_nettype none
module two_axis_step_pulse_generator_top
	import tspg_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    action,
	input  wire logic [FIELD_BITS-1:0]   target_x,
	input  wire logic [FIELD_BITS-1:0]   target_y,
	input  wire logic [FIELD_BITS-1:0]   velocity,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic                         step_x,
	output logic                         dir_x,
	output logic                         step_y,
	output logic                         dir_y,
	output logic [FIELD_BITS-1:0]        pos_x,
	output logic [FIELD_BITS-1:0]        pos_y,
	output logic                         done_x,
	output logic                         done_y,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [FIELD_BITS-1:0]   cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// registers are plain flops, always writable
	assign cfg_ready = 1'b1;

	tspg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	tspg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.action    (action),
		.target_x  (target_x),
		.target_y  (target_y),
		.velocity  (velocity),
		.step_x    (step_x),
		.dir_x     (dir_x),
		.step_y    (step_y),
		.dir_y     (dir_y),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.done_x    (done_x),
		.done_y    (done_y)
	);

endmodule
`default_nettype wire

/* hw/rtl/tspg_chk.sv */
// Port-level checker for the step pulse generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tspg_chk
	import tspg_pkg::*;
(
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    in_valid,
	input wire logic                    in_ready,
	input wire logic                    out_valid,
	input wire logic                    out_ready,
	input wire logic                    step_x,
	input wire logic                    step_y,
	input wire logic [FIELD_BITS-1:0]   pos_x,
	input wire logic [FIELD_BITS-1:0]   pos_y,
	input wire logic                    done_x,
	input wire logic                    done_y
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
			&& $stable(step_x) && $stable(step_y) && $stable(done_x) && $stable(done_y))
		else $error("result word changed while stalled");

	// one word in work at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in work");

	// an axis that steps cannot be finished in the same word
	a_step_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(step_x && done_x) && !(step_y && done_y))
		else $error("step pulse on a finished axis");

	// a result only appears as a word in work completes
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while idle");

endmodule

bind two_axis_step_pulse_generator_top tspg_chk u_tspg_chk (.*);
`default_nettype wire
